/* hdl/i2csbh_pkg.sv */
package i2csbh_pkg;

    // Store sizes
    localparam int RX_DEPTH = 32;
    localparam int TX_DEPTH = 8;

    localparam int RX_IDX_W = $clog2(RX_DEPTH);
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int TX_IDX_W = $clog2(TX_DEPTH);
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

    // Byte constants
    localparam logic [7:0] ADDR_MASK   = 8'hFE;
    localparam logic [7:0] STATUS_BYTE = 8'h55;
    localparam logic [7:0] INIT_FIRST  = 8'd88;

    // Operation codes
    typedef enum logic [1:0] {
        OP_BUS  = 2'd0,
        OP_POLL = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // One incoming word
    typedef struct packed {
        logic [1:0] op;
        logic       read_not_write;
        logic       master_nack;
        logic       is_data;
        logic       stop_seen;
        logic [7:0] bus_byte;
        logic [3:0] status_lines;
        logic [4:0] read_index;
    } evt_t;

    // One result word
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       transmission_done;
        logic [5:0] received_count;
        logic [7:0] read_byte;
        logic       stop_detect_enable;
        logic [7:0] captured_address;
    } res_t;

    // Handshake between the stages
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

/* hdl/i2csbh_in_reg.sv */
module i2csbh_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  i2csbh_pkg::evt_t  evt_in,
    input  logic              advance,
    output i2csbh_pkg::evt_t  evt_out,
    output logic              evt_valid
);
    import i2csbh_pkg::*;

    logic valid_reg;
    evt_t evt_reg;

    // Take a new word when empty or when the held one moves on this cycle
    assign s_ready   = !valid_reg || advance;
    assign evt_out   = evt_reg;
    assign evt_valid = valid_reg;

    // Hold the word until the engine consumes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            evt_reg <= evt_in;
        end
    end

endmodule

/* hdl/i2csbh_engine.sv */
module i2csbh_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  i2csbh_pkg::evt_t  evt,
    input  logic              fire,
    output i2csbh_pkg::res_t  res
);
    import i2csbh_pkg::*;

    logic [7:0]          rx_store_reg [RX_DEPTH];
    logic [7:0]          tx_store_reg [TX_DEPTH];
    logic [TX_CNT_W-1:0] tx_index_reg, tx_index_next;
    logic [RX_CNT_W-1:0] rx_count_reg, rx_count_next;
    logic                sent_reg, sent_next;
    logic                rcvd_reg, rcvd_next;
    logic                stop_en_reg, stop_en_next;
    logic [7:0]          addr_reg, addr_next;
    logic                refill;
    logic                rx_write;

    // Work out the result and the next state for the held word
    always_comb begin
        tx_index_next = tx_index_reg;
        rx_count_next = rx_count_reg;
        sent_next     = sent_reg;
        rcvd_next     = rcvd_reg;
        stop_en_next  = stop_en_reg;
        addr_next     = addr_reg;
        refill        = 1'b0;
        rx_write      = 1'b0;
        res           = '0;
        unique case (op_t'(evt.op))
            OP_BUS: begin
                if (evt.read_not_write) begin
                    if (evt.master_nack) begin
                        sent_next = 1'b1;
                    end else begin
                        res.tx_valid = 1'b1;
                        if (!evt.is_data) begin
                            // Read address: refill and send the status byte first
                            addr_next     = evt.bus_byte & ADDR_MASK;
                            refill        = 1'b1;
                            res.tx_byte   = STATUS_BYTE;
                            tx_index_next = TX_CNT_W'(1);
                        end else if (tx_index_reg < TX_CNT_W'(TX_DEPTH)) begin
                            res.tx_byte   = tx_store_reg[tx_index_reg[TX_IDX_W-1:0]];
                            tx_index_next = tx_index_reg + TX_CNT_W'(1);
                        end
                    end
                end else if (evt.stop_seen) begin
                    rcvd_next    = 1'b1;
                    stop_en_next = 1'b0;
                end else if (!evt.is_data) begin
                    addr_next     = evt.bus_byte & ADDR_MASK;
                    rx_count_next = '0;
                    stop_en_next  = 1'b1;
                end else if (rx_count_reg < RX_CNT_W'(RX_DEPTH)) begin
                    // Drop the byte once the receive store is full
                    rx_write      = 1'b1;
                    rx_count_next = rx_count_reg + RX_CNT_W'(1);
                end
            end
            OP_POLL: begin
                if (rcvd_reg) begin
                    rcvd_next          = 1'b0;
                    res.received_count = 6'(rx_count_reg);
                end
            end
            OP_READ: begin
                if (32'(evt.read_index) < 32'(RX_DEPTH)) begin
                    res.read_byte = rx_store_reg[evt.read_index[RX_IDX_W-1:0]];
                end
            end
            default: begin
            end
        endcase
        res.transmission_done  = sent_next;
        res.stop_detect_enable = stop_en_next;
        res.captured_address   = addr_next;
    end

    // Hold the control state and both stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_index_reg <= '0;
            rx_count_reg <= '0;
            sent_reg     <= 1'b0;
            rcvd_reg     <= 1'b0;
            stop_en_reg  <= 1'b0;
            addr_reg     <= '0;
            for (int i = 0; i < RX_DEPTH; i++) begin
                rx_store_reg[RX_IDX_W'(i)] <= '0;
            end
            for (int i = 0; i < TX_DEPTH; i++) begin
                tx_store_reg[TX_IDX_W'(i)] <= (i == 0) ? INIT_FIRST : 8'(i);
            end
        end else if (fire) begin
            tx_index_reg <= tx_index_next;
            rx_count_reg <= rx_count_next;
            sent_reg     <= sent_next;
            rcvd_reg     <= rcvd_next;
            stop_en_reg  <= stop_en_next;
            addr_reg     <= addr_next;
            if (rx_write) begin
                rx_store_reg[rx_count_reg[RX_IDX_W-1:0]] <= evt.bus_byte;
            end
            if (refill) begin
                tx_store_reg[0] <= STATUS_BYTE;
                for (int k = 0; k < 4; k++) begin
                    tx_store_reg[TX_IDX_W'(k + 1)] <= {7'd0, evt.status_lines[k]};
                end
            end
        end
    end

endmodule

/* hdl/i2csbh_out_reg.sv */
module i2csbh_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  i2csbh_pkg::res_t  res_in,
    input  i2csbh_pkg::hs_t   up,
    output logic              free,
    output i2csbh_pkg::res_t  res_out,
    output logic              m_valid,
    input  logic              m_ready
);
    import i2csbh_pkg::*;

    logic valid_reg;
    res_t res_reg;

    // Room for a new result when empty or when the held one is taken now
    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign res_out = res_reg;

    // Load the result word and hold it until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= up.valid;
        end
        if (up.valid && up.ready) begin
            res_reg <= res_in;
        end
    end

endmodule

/* hdl/i2c_slave_buffer_handler_core.sv */
// Byte-event handler of a 7-bit I2C slave. Each input word is a bus event
// (master read, master NACK, address byte, data byte or stop), a poll of the
// read-and-clear received count, a read of one receive-store entry or a no-op;
// each gives exactly one result word. A read address refills the eight-byte send
// store with 0x55 and the four status lines and then streams it, with zeros
// after its end; write data fills a 32-byte receive store that saturates.
// Every word is worked out combinationally between the input register and the
// result register, so one word is taken per clock when the result side keeps
// up; the result word is registered once the result register has room.
module i2c_slave_buffer_handler_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic       s_read_not_write,
    input  logic       s_master_nack,
    input  logic       s_is_data,
    input  logic       s_stop_seen,
    input  logic [7:0] s_bus_byte,
    input  logic [3:0] s_status_lines,
    input  logic [4:0] s_read_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_tx_valid,
    output logic       m_transmission_done,
    output logic [5:0] m_received_count,
    output logic [7:0] m_read_byte,
    output logic       m_stop_detect_enable,
    output logic [7:0] m_captured_address
);
    import i2csbh_pkg::*;

    evt_t evt_in, evt_held;
    res_t res_comb, res_held;
    logic evt_valid;
    logic out_free;
    logic fire;
    hs_t  stage_hs;

    // Pack the input word
    assign evt_in = '{op: s_op, read_not_write: s_read_not_write,
                      master_nack: s_master_nack, is_data: s_is_data,
                      stop_seen: s_stop_seen, bus_byte: s_bus_byte,
                      status_lines: s_status_lines, read_index: s_read_index};

    // Advance the held word when the result register has room
    assign fire     = evt_valid && out_free;
    assign stage_hs = '{valid: evt_valid, ready: out_free};

    i2csbh_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .evt_in    (evt_in),
        .advance   (out_free),
        .evt_out   (evt_held),
        .evt_valid (evt_valid)
    );

    i2csbh_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .evt     (evt_held),
        .fire    (fire),
        .res     (res_comb)
    );

    i2csbh_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .res_in  (res_comb),
        .up      (stage_hs),
        .free    (out_free),
        .res_out (res_held),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

    // Unpack the result word
    assign m_tx_byte            = res_held.tx_byte;
    assign m_tx_valid           = res_held.tx_valid;
    assign m_transmission_done  = res_held.transmission_done;
    assign m_received_count     = res_held.received_count;
    assign m_read_byte          = res_held.read_byte;
    assign m_stop_detect_enable = res_held.stop_detect_enable;
    assign m_captured_address   = res_held.captured_address;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import i2csbh_pkg::*;

    localparam int N_WORDS     = 1650;
    localparam int CALM_WORDS  = 200;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = 400;
    localparam int STUCK_LIMIT = 3000;
    localparam int TAIL_CYCLES = 10;

    typedef struct {
        evt_t w;
        bit   typed;
        res_t want;
    } row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_op;
    logic       s_read_not_write;
    logic       s_master_nack;
    logic       s_is_data;
    logic       s_stop_seen;
    logic [7:0] s_bus_byte;
    logic [3:0] s_status_lines;
    logic [4:0] s_read_index;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_tx_byte;
    logic       m_tx_valid;
    logic       m_transmission_done;
    logic [5:0] m_received_count;
    logic [7:0] m_read_byte;
    logic       m_stop_detect_enable;
    logic [7:0] m_captured_address;

    // Shadow of the handler state
    logic [7:0]  rx_mem [RX_DEPTH];
    logic [7:0]  tx_mem [TX_DEPTH];
    int unsigned tx_ptr;
    int unsigned rx_fill;
    bit          sent_q;
    bit          rcvd_q;
    bit          stop_en_q;
    logic [7:0]  addr_q;

    res_t results_due [$];
    bit   cur_typed;
    res_t cur_want;
    int   n_bad       = 0;
    int   n_in        = 0;
    int   n_words     = 0;
    int   smooth_left = 0;
    int   stuck       = 0;
    bit   calm        = 1'b0;
    bit   rx_holding  = 1'b0;
    bit   hold_done   = 1'b0;

    i2c_slave_buffer_handler_core i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_op                 (s_op),
        .s_read_not_write     (s_read_not_write),
        .s_master_nack        (s_master_nack),
        .s_is_data            (s_is_data),
        .s_stop_seen          (s_stop_seen),
        .s_bus_byte           (s_bus_byte),
        .s_status_lines       (s_status_lines),
        .s_read_index         (s_read_index),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_tx_byte            (m_tx_byte),
        .m_tx_valid           (m_tx_valid),
        .m_transmission_done  (m_transmission_done),
        .m_received_count     (m_received_count),
        .m_read_byte          (m_read_byte),
        .m_stop_detect_enable (m_stop_detect_enable),
        .m_captured_address   (m_captured_address)
    );

    always #6 aclk = ~aclk;

    // Clear the shadow state to its reset contents
    function automatic void clear_handler_state();
        foreach (rx_mem[i]) rx_mem[i] = 8'd0;
        foreach (tx_mem[i]) tx_mem[i] = 8'(i);
        tx_mem[0] = INIT_FIRST;
        tx_ptr    = 0;
        rx_fill   = 0;
        sent_q    = 1'b0;
        rcvd_q    = 1'b0;
        stop_en_q = 1'b0;
        addr_q    = 8'd0;
    endfunction

    // Apply one event to the shadow state and return the result word it gives
    function automatic res_t handler_step(evt_t w);
        res_t r;
        r = '0;
        case (op_t'(w.op))
            OP_BUS: begin
                if (w.read_not_write) begin
                    if (w.master_nack) begin
                        sent_q = 1'b1;
                    end else begin
                        // A read address reloads the send store
                        if (!w.is_data) begin
                            addr_q    = w.bus_byte & ADDR_MASK;
                            tx_ptr    = 0;
                            tx_mem[0] = STATUS_BYTE;
                            for (int k = 0; k < 4; k++)
                                tx_mem[TX_IDX_W'(k + 1)] = {7'd0, w.status_lines[k]};
                        end
                        r.tx_valid = 1'b1;
                        // Hold at the end of the store and send zeros
                        if (tx_ptr < TX_DEPTH) begin
                            r.tx_byte = tx_mem[tx_ptr[TX_IDX_W-1:0]];
                            tx_ptr++;
                        end
                    end
                end else if (w.stop_seen) begin
                    rcvd_q    = 1'b1;
                    stop_en_q = 1'b0;
                end else if (!w.is_data) begin
                    addr_q    = w.bus_byte & ADDR_MASK;
                    rx_fill   = 0;
                    stop_en_q = 1'b1;
                end else if (rx_fill < RX_DEPTH) begin
                    // Drop data once the receive store is full
                    rx_mem[rx_fill[RX_IDX_W-1:0]] = w.bus_byte;
                    rx_fill++;
                end
            end
            OP_POLL: begin
                if (rcvd_q) begin
                    rcvd_q           = 1'b0;
                    r.received_count = 6'(rx_fill);
                end
            end
            OP_READ: begin
                if (w.read_index < RX_DEPTH)
                    r.read_byte = rx_mem[w.read_index];
            end
            default: ;
        endcase
        r.transmission_done  = sent_q;
        r.stop_detect_enable = stop_en_q;
        r.captured_address   = addr_q;
        return r;
    endfunction

    function automatic evt_t ev(op_t op, bit rnw, bit nack, bit dat, bit stp,
                                logic [7:0] b, logic [3:0] lines, logic [4:0] idx);
        evt_t w;
        w.op             = op;
        w.read_not_write = rnw;
        w.master_nack    = nack;
        w.is_data        = dat;
        w.stop_seen      = stp;
        w.bus_byte       = b;
        w.status_lines   = lines;
        w.read_index     = idx;
        return w;
    endfunction

    function automatic res_t rs(logic [7:0] txb, bit txv, bit done, logic [5:0] cnt,
                                logic [7:0] rd, bit sen, logic [7:0] adr);
        res_t r;
        r.tx_byte            = txb;
        r.tx_valid           = txv;
        r.transmission_done  = done;
        r.received_count     = cnt;
        r.read_byte          = rd;
        r.stop_detect_enable = sen;
        r.captured_address   = adr;
        return r;
    endfunction

    // Bus event with the given flags and random payload elsewhere
    function automatic evt_t bus_word(bit rnw, bit nack, bit dat, bit stp);
        return ev(OP_BUS, rnw, nack, dat, stp, 8'($urandom_range(0, 255)),
                  4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
    endfunction

    function automatic evt_t rand_word(op_t op);
        evt_t w;
        w    = evt_t'($bits(evt_t)'($urandom));
        w.op = op;
        return w;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_bad++;
        end
    endtask

    // Offer one word, wait for it to be taken, then maybe idle for a burst
    task automatic offer(evt_t w, bit typed = 1'b0, res_t want = '0);
        int gap;
        s_op             <= w.op;
        s_read_not_write <= w.read_not_write;
        s_master_nack    <= w.master_nack;
        s_is_data        <= w.is_data;
        s_stop_seen      <= w.stop_seen;
        s_bus_byte       <= w.bus_byte;
        s_status_lines   <= w.status_lines;
        s_read_index     <= w.read_index;
        s_valid          <= 1'b1;
        cur_typed = typed;
        cur_want  = want;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (w.op != OP_NONE) n_words++;
        if (smooth_left > 0) begin
            smooth_left--;
        end else if (!calm && !rx_holding && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end else if ($urandom_range(0, 29) == 0) begin
            smooth_left = $urandom_range(20, 60);
        end
    endtask

    // Stop offering until every outstanding result word has come back
    task automatic drain_all();
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Result side: random stalls, one long hold-off, none near the end
    initial begin : result_side
        int n;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            n = $urandom_range(0, 31);
            if (!hold_done && n_in >= HOLD_AT) begin
                rx_holding = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_ready <= 1'b1;
                hold_done  = 1'b1;
                rx_holding = 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else if (n < 4) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (n == 4) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Predict on each accepted event, check each accepted result, watch for hangs
    always @(posedge aclk) begin : monitor
        evt_t taken;
        res_t seen;
        res_t due;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                taken = {s_op, s_read_not_write, s_master_nack, s_is_data, s_stop_seen,
                         s_bus_byte, s_status_lines, s_read_index};
                due = handler_step(taken);
                if (cur_typed) due = cur_want;
                results_due.push_back(due);
                n_in++;
            end
            if (m_valid && m_ready) begin
                seen = {m_tx_byte, m_tx_valid, m_transmission_done, m_received_count,
                        m_read_byte, m_stop_detect_enable, m_captured_address};
                if (results_due.size() == 0) begin
                    $error("result word with nothing expected");
                    n_bad++;
                end else begin
                    due = results_due.pop_front();
                    check_field("tx_byte", due.tx_byte, seen.tx_byte);
                    check_field("tx_valid", 8'(due.tx_valid), 8'(seen.tx_valid));
                    check_field("transmission_done", 8'(due.transmission_done),
                                8'(seen.transmission_done));
                    check_field("received_count", 8'(due.received_count),
                                8'(seen.received_count));
                    check_field("read_byte", due.read_byte, seen.read_byte);
                    check_field("stop_detect_enable", 8'(due.stop_detect_enable),
                                8'(seen.stop_detect_enable));
                    check_field("captured_address", due.captured_address,
                                seen.captured_address);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) stuck = 0;
            else stuck++;
            if (stuck >= STUCK_LIMIT) begin
                $error("no word moved for %0d cycles", STUCK_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : stimulus
        row_t plan [$];
        int   len;
        int   pick;
        bit   paused_mid;
        paused_mid       = 1'b0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_op             = OP_BUS;
        s_read_not_write = 1'b0;
        s_master_nack    = 1'b0;
        s_is_data        = 1'b0;
        s_stop_seen      = 1'b0;
        s_bus_byte       = 8'd0;
        s_status_lines   = 4'd0;
        s_read_index     = 5'd0;
        cur_typed        = 1'b0;
        cur_want         = '0;
        clear_handler_state();

        // Directed words: reset state, extremes and each corner of the handler
        plan.push_back('{ev(OP_POLL, 1, 1, 1, 1, 8'hFF, 4'hF, 5'd31), 1'b1,
                         rs(0, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{ev(OP_READ, 0, 0, 0, 0, 8'h00, 4'h0, 5'd31), 1'b1,
                         rs(0, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{ev(OP_NONE, 1, 0, 0, 1, 8'hFF, 4'hF, 5'd31), 1'b1,
                         rs(0, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{ev(OP_BUS, 1, 0, 1, 0, 8'h00, 4'h0, 5'd0), 1'b1,
                         rs(INIT_FIRST, 1, 0, 0, 0, 0, 0)});
        // stop flag on a read event is ignored
        plan.push_back('{ev(OP_BUS, 1, 0, 1, 1, 8'hFF, 4'hF, 5'd0), 1'b0, '0});
        plan.push_back('{ev(OP_BUS, 1, 0, 0, 0, 8'hFF, 4'b1010, 5'd0), 1'b1,
                         rs(STATUS_BYTE, 1, 0, 0, 0, 0, 8'hFE)});
        // run past the end of the send store
        repeat (8) plan.push_back('{ev(OP_BUS, 1, 0, 1, 0, 8'h5A, 4'h0, 5'd0), 1'b0, '0});
        plan.push_back('{ev(OP_BUS, 1, 1, 1, 0, 8'h00, 4'h0, 5'd0), 1'b1,
                         rs(0, 0, 1, 0, 0, 0, 8'hFE)});
        plan.push_back('{ev(OP_BUS, 0, 0, 0, 0, 8'h00, 4'h0, 5'd0), 1'b1,
                         rs(0, 0, 1, 0, 0, 1, 0)});
        plan.push_back('{ev(OP_BUS, 0, 0, 1, 0, 8'hFF, 4'h0, 5'd0), 1'b0, '0});
        plan.push_back('{ev(OP_BUS, 0, 0, 1, 0, 8'h00, 4'h0, 5'd0), 1'b0, '0});
        plan.push_back('{ev(OP_BUS, 0, 0, 1, 1, 8'h00, 4'h0, 5'd0), 1'b0, '0});
        plan.push_back('{ev(OP_POLL, 0, 0, 0, 0, 8'h00, 4'h0, 5'd0), 1'b0, '0});
        plan.push_back('{ev(OP_POLL, 0, 0, 0, 0, 8'h00, 4'h0, 5'd0), 1'b0, '0});
        plan.push_back('{ev(OP_READ, 0, 0, 0, 0, 8'h00, 4'h0, 5'd0), 1'b0, '0});
        plan.push_back('{ev(OP_READ, 0, 0, 0, 0, 8'h00, 4'h0, 5'd1), 1'b0, '0});
        plan.push_back('{ev(OP_BUS, 0, 1, 0, 0, 8'hFF, 4'hF, 5'd31), 1'b0, '0});
        plan.push_back('{ev(OP_POLL, 0, 0, 0, 1, 8'h00, 4'h0, 5'd0), 1'b0, '0});

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) offer(plan[i].w, plan[i].typed, plan[i].want);
        drain_all();

        // Random transactions with random content, plus some noise
        while (n_words < N_WORDS) begin
            calm = (n_words >= N_WORDS - CALM_WORDS);
            if (!paused_mid && n_words >= N_WORDS / 2) begin
                drain_all();
                paused_mid = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // master read: address, data bytes, usually closed by a NACK
                offer(bus_word(1, 0, 0, 1'($urandom_range(0, 1))));
                len = $urandom_range(0, 11);
                repeat (len) offer(bus_word(1, 0, 1, 1'($urandom_range(0, 1))));
                if ($urandom_range(0, 4) != 0) offer(bus_word(1, 1, 1'($urandom_range(0, 1)),
                                                              1'($urandom_range(0, 1))));
            end else if (pick < 70) begin
                // master write: address, data bytes, usually closed by a stop
                offer(bus_word(0, 1'($urandom_range(0, 1)), 0, 0));
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 40)
                                                  : $urandom_range(0, 12);
                repeat (len) offer(bus_word(0, 1'($urandom_range(0, 1)), 1, 0));
                if ($urandom_range(0, 6) != 0)
                    offer(bus_word(0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1));
                if ($urandom_range(0, 1) != 0) offer(rand_word(OP_POLL));
            end else if (pick < 85) begin
                // software side: poll, then read back a few entries
                offer(rand_word(OP_POLL));
                len = $urandom_range(0, 6);
                repeat (len) offer(rand_word(OP_READ));
            end else begin
                offer(rand_word(op_t'($urandom_range(0, 3))));
            end
        end

        drain_all();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_bad == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
